// File: hdl/utrb_pkg.sv
// Package for the UART TX/RX ring buffer unit.
// Item types, ring geometry, request codes and internal control structs.
// No dependencies.
package utrb_pkg;

  localparam int TX_DEPTH = 256;
  localparam int RX_DEPTH = 128;
  localparam int TX_AW    = $clog2(TX_DEPTH);
  localparam int RX_AW    = $clog2(RX_DEPTH);

  localparam logic [1:0] REQ_WRITE = 2'd0;
  localparam logic [1:0] REQ_EVENT = 2'd1;
  localparam logic [1:0] REQ_READ  = 2'd2;

  typedef struct packed {
    logic [1:0] req_type;
    logic [7:0] data_byte;
    logic       rx_ready;
    logic       overrun;
    logic       tx_empty;
  } in_item_t;

  typedef struct packed {
    logic       write_accepted;
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       rx_dropped;
    logic       overrun_cleared;
    logic       rx_valid;
    logic [7:0] rx_byte;
    logic       rx_was_empty;
    logic       tx_irq_enabled;
    logic [7:0] tx_fill;
    logic [6:0] rx_fill;
  } out_item_t;

  // RAM accesses issued for one transfer
  typedef struct packed {
    logic             tx_we;
    logic [TX_AW-1:0] tx_waddr;
    logic [7:0]       tx_wdata;
    logic             tx_re;
    logic [TX_AW-1:0] tx_raddr;
    logic             rx_we;
    logic [RX_AW-1:0] rx_waddr;
    logic [7:0]       rx_wdata;
    logic             rx_re;
    logic [RX_AW-1:0] rx_raddr;
  } ram_op_t;

  // status of one item, waiting for its RAM read data
  typedef struct packed {
    logic       write_accepted;
    logic       tx_pop;
    logic       rx_dropped;
    logic       overrun_cleared;
    logic       rx_pop;
    logic       rx_valid;
    logic       rx_was_empty;
    logic       tx_irq;
    logic [7:0] tx_fill;
    logic [6:0] rx_fill;
  } stage_t;

endpackage

// File: hdl/uart_tx_rx_ring_buffers_unit.sv
// Top level of the UART TX/RX ring buffer unit.
// Depends on utrb_pkg, utrb_ctrl and utrb_ram.
//
//  port group   direction  handshake            payload
//  in_*         input      in_valid / in_ready   utrb_pkg::in_item_t
//  out_*        output     out_valid / out_ready utrb_pkg::out_item_t
//  cfg_*        input      cfg_we                cfg_wdata (rx_deliver_enable)
//
// One transfer per cycle sustained while out_ready stays high.
// Ring state is decided at input transfer, the RAM read completes in the middle
// stage, and the result register holds the item until out_ready.
// Reset is synchronous and clears the pointers, the enable and both stages;
// ring RAM contents need no clearing.
// A stall on out_ready backs up through the middle stage to in_ready.
module uart_tx_rx_ring_buffers_unit (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  utrb_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output utrb_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic                cfg_wdata
);

  utrb_pkg::ram_op_t ram_op;
  utrb_pkg::stage_t  status;
  utrb_pkg::stage_t  s1_r;
  logic              s1_valid_r;
  logic              s1_adv;
  logic              accept;
  logic              deliver_en_r;
  logic [7:0]        tx_rdata, rx_rdata;
  utrb_pkg::out_item_t out_nxt;
  utrb_pkg::out_item_t out_r;
  logic              out_valid_r;

  assign s1_adv   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready = !s1_valid_r || s1_adv;
  assign accept   = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deliver_en_r <= 1'b0;
    end else if (cfg_we) begin
      deliver_en_r <= cfg_wdata;
    end
  end

  utrb_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .accept     (accept),
    .req        (in_data),
    .deliver_en (deliver_en_r),
    .ram_op     (ram_op),
    .status     (status)
  );

  utrb_ram #(.WIDTH(8), .DEPTH(utrb_pkg::TX_DEPTH)) u_tx_ram (
    .clk   (clk),
    .we    (ram_op.tx_we),
    .waddr (ram_op.tx_waddr),
    .wdata (ram_op.tx_wdata),
    .re    (ram_op.tx_re),
    .raddr (ram_op.tx_raddr),
    .rdata (tx_rdata)
  );

  utrb_ram #(.WIDTH(8), .DEPTH(utrb_pkg::RX_DEPTH)) u_rx_ram (
    .clk   (clk),
    .we    (ram_op.rx_we),
    .waddr (ram_op.rx_waddr),
    .wdata (ram_op.rx_wdata),
    .re    (ram_op.rx_re),
    .raddr (ram_op.rx_raddr),
    .rdata (rx_rdata)
  );

  // middle stage: read data only changes on a new transfer, so it holds during a stall
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_r <= status;
    end
  end

  always_comb begin
    out_nxt.write_accepted  = s1_r.write_accepted;
    out_nxt.tx_valid        = s1_r.tx_pop;
    out_nxt.tx_byte         = s1_r.tx_pop ? tx_rdata : 8'd0;
    out_nxt.rx_dropped      = s1_r.rx_dropped;
    out_nxt.overrun_cleared = s1_r.overrun_cleared;
    out_nxt.rx_valid        = s1_r.rx_valid;
    out_nxt.rx_byte         = s1_r.rx_pop ? rx_rdata : 8'd0;
    out_nxt.rx_was_empty    = s1_r.rx_was_empty;
    out_nxt.tx_irq_enabled  = s1_r.tx_irq;
    out_nxt.tx_fill         = s1_r.tx_fill;
    out_nxt.rx_fill         = s1_r.rx_fill;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_r <= out_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

`ifndef ASSERT_OFF
  a_write_sets_irq: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.write_accepted |-> out_data.tx_irq_enabled)
    else $error("accepted write without transmit interrupt enable");

  a_empty_read_fill: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.rx_was_empty |-> out_data.rx_fill == 7'd0)
    else $error("rx ring reported empty with nonzero fill");

  a_tx_byte_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.tx_valid |-> out_data.tx_byte == 8'd0)
    else $error("tx_byte nonzero without tx_valid");

  a_mid_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s1_adv |=> s1_valid_r && $stable(s1_r))
    else $error("middle stage lost or changed a stalled item");
`endif

endmodule

// File: hdl/utrb_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
module utrb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

// File: hdl/utrb_ctrl.sv
// Ring pointer and interrupt-enable control for the TX and RX rings.
// Decides each transfer in one pass; depends on utrb_pkg.
module utrb_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  utrb_pkg::in_item_t req,
  input  logic              deliver_en,
  output utrb_pkg::ram_op_t ram_op,
  output utrb_pkg::stage_t  status
);

  logic [utrb_pkg::TX_AW-1:0] tx_wp_r, tx_rp_r, tx_wp_nxt, tx_rp_nxt, tx_wp_inc, tx_rp_inc;
  logic [utrb_pkg::RX_AW-1:0] rx_wp_r, rx_rp_r, rx_wp_nxt, rx_rp_nxt, rx_wp_inc, rx_rp_inc;
  logic                       tx_irq_r, tx_irq_nxt;

  assign tx_wp_inc = tx_wp_r + 1'b1;
  assign tx_rp_inc = tx_rp_r + 1'b1;
  assign rx_wp_inc = rx_wp_r + 1'b1;
  assign rx_rp_inc = rx_rp_r + 1'b1;

  always_comb begin
    tx_wp_nxt  = tx_wp_r;
    tx_rp_nxt  = tx_rp_r;
    rx_wp_nxt  = rx_wp_r;
    rx_rp_nxt  = rx_rp_r;
    tx_irq_nxt = tx_irq_r;
    status     = '0;

    ram_op          = '0;
    ram_op.tx_waddr = tx_wp_r;
    ram_op.tx_wdata = req.data_byte;
    ram_op.tx_raddr = tx_rp_r;
    ram_op.rx_waddr = rx_wp_r;
    ram_op.rx_wdata = req.data_byte;
    ram_op.rx_raddr = rx_rp_r;

    unique case (req.req_type)
      utrb_pkg::REQ_WRITE: begin
        // one slot stays empty: full when the next write slot is the read slot
        if (tx_wp_inc != tx_rp_r) begin
          ram_op.tx_we          = 1'b1;
          tx_wp_nxt             = tx_wp_inc;
          tx_irq_nxt            = 1'b1;
          status.write_accepted = 1'b1;
        end
      end
      utrb_pkg::REQ_EVENT: begin
        if (req.rx_ready) begin
          if (rx_wp_inc != rx_rp_r) begin
            ram_op.rx_we = 1'b1;
            rx_wp_nxt    = rx_wp_inc;
          end else begin
            status.rx_dropped = 1'b1;
          end
        end else if (req.overrun) begin
          status.overrun_cleared = 1'b1;
        end
        if (tx_irq_r && req.tx_empty) begin
          if (tx_rp_r != tx_wp_r) begin
            ram_op.tx_re  = 1'b1;
            status.tx_pop = 1'b1;
            tx_rp_nxt     = tx_rp_inc;
          end
          if (tx_rp_nxt == tx_wp_r) begin
            tx_irq_nxt = 1'b0;
          end
        end
      end
      utrb_pkg::REQ_READ: begin
        if (rx_rp_r == rx_wp_r) begin
          status.rx_was_empty = 1'b1;
        end else begin
          ram_op.rx_re    = 1'b1;
          status.rx_pop   = 1'b1;
          status.rx_valid = deliver_en;
          rx_rp_nxt       = rx_rp_inc;
        end
      end
      default: begin
      end
    endcase

    status.tx_irq  = tx_irq_nxt;
    status.tx_fill = 8'(tx_wp_nxt - tx_rp_nxt);
    status.rx_fill = 7'(rx_wp_nxt - rx_rp_nxt);

    if (!accept) begin
      ram_op.tx_we = 1'b0;
      ram_op.tx_re = 1'b0;
      ram_op.rx_we = 1'b0;
      ram_op.rx_re = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tx_wp_r  <= '0;
      tx_rp_r  <= '0;
      rx_wp_r  <= '0;
      rx_rp_r  <= '0;
      tx_irq_r <= 1'b0;
    end else if (accept) begin
      tx_wp_r  <= tx_wp_nxt;
      tx_rp_r  <= tx_rp_nxt;
      rx_wp_r  <= rx_wp_nxt;
      rx_rp_r  <= rx_rp_nxt;
      tx_irq_r <= tx_irq_nxt;
    end
  end

endmodule
